[rtl/lslf_pkg.sv]
package lslf_pkg;

    localparam int COORD_W  = 12;
    localparam int FIXED_W  = 32;
    localparam int POINTS_W = 11;

    localparam logic [FIXED_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [FIXED_W-1:0] SAT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [COORD_W-1:0] x_coord;
        logic [COORD_W-1:0] y_coord;
        logic               last_point;
    } t_point;

    typedef struct packed {
        logic signed [FIXED_W-1:0] slope_q;
        logic signed [FIXED_W-1:0] offset_q;
        logic                      degenerate;
        logic [POINTS_W-1:0]       points_used;
    } t_fit;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV
    } t_alu_op;

    typedef enum logic {
        ALU_IDLE,
        ALU_RUN
    } t_alu_st;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_ctl;

    typedef struct packed {
        logic done;
        logic borrow;
    } t_alu_sts;

    typedef enum logic [3:0] {
        SQ_IDLE,
        SQ_MUL_A,
        SQ_MUL_B,
        SQ_SUB_NUM,
        SQ_NEG_NUM,
        SQ_MUL_C,
        SQ_MUL_D,
        SQ_SUB_DEN,
        SQ_DIV_SLOPE,
        SQ_MUL_P,
        SQ_MUL_Q,
        SQ_OFF_SUM,
        SQ_OFF_NEG,
        SQ_MUL_ND,
        SQ_DIV_OFF,
        SQ_EMIT
    } t_seq_st;

endpackage

[rtl/lslf_accum.sv]
module lslf_accum #(
    parameter int MAX_POINTS = 1024,
    parameter int CW         = 12,
    parameter int NW         = 11,
    parameter int SW         = 23,
    parameter int XW         = 35
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  lslf_pkg::t_point i_point,
    output logic             o_fire,
    output logic [NW-1:0]    o_n,
    output logic [SW-1:0]    o_sx,
    output logic [SW-1:0]    o_sy,
    output logic [XW-1:0]    o_sxy,
    output logic [XW-1:0]    o_sxx
);
    import lslf_pkg::*;

    logic [NW-1:0]   r_cnt, n_cnt;
    logic [SW-1:0]   r_sx, n_sx, r_sy, n_sy;
    logic [XW-1:0]   r_sxy, n_sxy, r_sxx, n_sxx;
    logic [CW-1:0]   x_m, y_m;
    logic [2*CW-1:0] xy, xx;

    // drop coordinate bits above the configured width
    assign x_m = i_point.x_coord[CW-1:0];
    assign y_m = i_point.y_coord[CW-1:0];
    assign xy  = x_m * y_m;
    assign xx  = x_m * x_m;

    assign n_cnt = r_cnt + 1'b1;
    assign n_sx  = r_sx + SW'(x_m);
    assign n_sy  = r_sy + SW'(y_m);
    assign n_sxy = r_sxy + XW'(xy);
    assign n_sxx = r_sxx + XW'(xx);

    // a full set closes even without the mark
    assign o_fire = i_accept && (i_point.last_point || (n_cnt == NW'(MAX_POINTS)));
    assign o_n    = n_cnt;
    assign o_sx   = n_sx;
    assign o_sy   = n_sy;
    assign o_sxy  = n_sxy;
    assign o_sxx  = n_sxx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_fire) begin
            r_cnt <= '0;
            r_sx  <= '0;
            r_sy  <= '0;
            r_sxy <= '0;
            r_sxx <= '0;
        end else if (i_accept) begin
            r_cnt <= n_cnt;
            r_sx  <= n_sx;
            r_sy  <= n_sy;
            r_sxy <= n_sxy;
            r_sxx <= n_sxx;
        end
    end

endmodule

[rtl/lslf_alu.sv]
module lslf_alu #(
    parameter int RW = 86,
    parameter int MW = 23
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lslf_pkg::t_alu_ctl i_ctl,
    input  logic [RW-1:0]      i_a,
    input  logic [RW-1:0]      i_b,
    output lslf_pkg::t_alu_sts o_sts,
    output logic [RW-1:0]      o_res
);
    import lslf_pkg::*;

    localparam int CNTW = $clog2(RW);

    t_alu_st         r_st, n_st;
    t_alu_op         r_op, n_op;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [RW-1:0]   r_p, n_p;
    logic [RW-1:0]   r_s, n_s;
    logic [RW-1:0]   r_t, n_t;
    logic            r_done, n_done;
    logic            r_borrow, n_borrow;

    logic [RW:0]     add_a, add_b, add_sum;
    logic            add_sub;

    // the one adder: accumulate, subtract or trial-subtract
    always_comb begin
        unique case (r_op)
            ALU_ADD: begin
                add_a   = {1'b0, r_s};
                add_b   = {1'b0, r_t};
                add_sub = 1'b0;
            end
            ALU_SUB: begin
                add_a   = {1'b0, r_s};
                add_b   = {1'b0, r_t};
                add_sub = 1'b1;
            end
            ALU_MUL: begin
                add_a   = {1'b0, r_p};
                add_b   = {1'b0, r_s};
                add_sub = 1'b0;
            end
            ALU_DIV: begin
                add_a   = {r_p, r_s[RW-1]};
                add_b   = {1'b0, r_t};
                add_sub = 1'b1;
            end
            default: begin
                add_a   = '0;
                add_b   = '0;
                add_sub = 1'b0;
            end
        endcase
        add_sum = add_a + (add_b ^ {(RW+1){add_sub}}) + (RW+1)'(add_sub);
    end

    always_comb begin
        n_st     = r_st;
        n_op     = r_op;
        n_cnt    = r_cnt;
        n_p      = r_p;
        n_s      = r_s;
        n_t      = r_t;
        n_done   = 1'b0;
        n_borrow = r_borrow;
        unique case (r_st)
            ALU_IDLE: begin
                if (i_ctl.start) begin
                    n_op = i_ctl.op;
                    n_s  = i_a;
                    n_t  = i_b;
                    n_p  = '0;
                    n_st = ALU_RUN;
                    unique case (i_ctl.op) inside
                        ALU_ADD, ALU_SUB: n_cnt = '0;
                        ALU_MUL:          n_cnt = CNTW'(MW - 1);
                        ALU_DIV:          n_cnt = CNTW'(RW - 1);
                        default:          n_cnt = '0;
                    endcase
                end
            end
            ALU_RUN: begin
                unique case (r_op) inside
                    ALU_ADD, ALU_SUB: begin
                        n_p      = add_sum[RW-1:0];
                        n_borrow = add_sum[RW];
                    end
                    ALU_MUL: begin
                        if (r_t[0]) begin
                            n_p = add_sum[RW-1:0];
                        end
                        n_s = {r_s[RW-2:0], 1'b0};
                        n_t = {1'b0, r_t[RW-1:1]};
                    end
                    ALU_DIV: begin
                        // keep the shifted remainder when the trial goes negative
                        n_p = add_sum[RW] ? add_a[RW-1:0] : add_sum[RW-1:0];
                        n_s = {r_s[RW-2:0], ~add_sum[RW]};
                    end
                    default: begin
                        n_p = r_p;
                    end
                endcase
                if (r_cnt == '0) begin
                    n_done = 1'b1;
                    n_st   = ALU_IDLE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            default: begin
                n_st = ALU_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ALU_IDLE;
            r_done <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_cnt    <= n_cnt;
        r_p      <= n_p;
        r_s      <= n_s;
        r_t      <= n_t;
        r_borrow <= n_borrow;
    end

    assign o_res        = (r_op == ALU_DIV) ? r_s : r_p;
    assign o_sts.done   = r_done;
    assign o_sts.borrow = r_borrow;

endmodule

[rtl/lslf_seq.sv]
module lslf_seq #(
    parameter int NW        = 11,
    parameter int SW        = 23,
    parameter int XW        = 35,
    parameter int PW        = 46,
    parameter int RW        = 86,
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [NW-1:0]      i_n,
    input  logic [SW-1:0]      i_sx,
    input  logic [SW-1:0]      i_sy,
    input  logic [XW-1:0]      i_sxy,
    input  logic [XW-1:0]      i_sxx,
    output logic               o_busy,
    output lslf_pkg::t_alu_ctl o_alu_ctl,
    output logic [RW-1:0]      o_alu_a,
    output logic [RW-1:0]      o_alu_b,
    input  lslf_pkg::t_alu_sts i_alu_sts,
    input  logic [RW-1:0]      i_alu_res,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output lslf_pkg::t_fit     o_out_data
);
    import lslf_pkg::*;

    localparam int EW = (RW > FIXED_W) ? RW : FIXED_W + 1;

    t_seq_st            r_st, n_st;
    logic               r_go, n_go;
    logic [NW-1:0]      r_n, n_n;
    logic [SW-1:0]      r_sx, n_sx, r_sy, n_sy;
    logic [XW-1:0]      r_sxy, n_sxy, r_sxx, n_sxx;
    logic [RW-1:0]      r_ta, n_ta, r_tb, n_tb;
    logic [PW-1:0]      r_num, n_num, r_den, n_den;
    logic               r_num_neg, n_num_neg;
    logic               r_off_neg, n_off_neg;
    logic [FIXED_W-1:0] r_slope, n_slope, r_offset, n_offset;
    logic               r_deg, n_deg;
    t_fit               r_out, n_out;
    logic               r_out_valid, n_out_valid;
    logic               cap;

    function automatic logic [FIXED_W-1:0] f_sat(input logic [RW-1:0] mag, input logic neg);
        logic [EW-1:0] magx;
        logic          big;
        magx = EW'(mag);
        big  = (magx[EW-1:FIXED_W-1] != '0);
        if (neg) begin
            f_sat = big ? SAT_MIN : (FIXED_W'(0) - magx[FIXED_W-1:0]);
        end else begin
            f_sat = big ? SAT_MAX : magx[FIXED_W-1:0];
        end
    endfunction

    // take the unit's result once, on its done word
    assign cap = !r_go && i_alu_sts.done;

    always_comb begin
        n_st        = r_st;
        n_go        = 1'b0;
        n_n         = r_n;
        n_sx        = r_sx;
        n_sy        = r_sy;
        n_sxy       = r_sxy;
        n_sxx       = r_sxx;
        n_ta        = r_ta;
        n_tb        = r_tb;
        n_num       = r_num;
        n_den       = r_den;
        n_num_neg   = r_num_neg;
        n_off_neg   = r_off_neg;
        n_slope     = r_slope;
        n_offset    = r_offset;
        n_deg       = r_deg;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        o_alu_ctl.start = r_go;
        o_alu_ctl.op    = ALU_MUL;
        o_alu_a         = '0;
        o_alu_b         = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_st)
            SQ_IDLE: begin
                if (i_start) begin
                    n_n       = i_n;
                    n_sx      = i_sx;
                    n_sy      = i_sy;
                    n_sxy     = i_sxy;
                    n_sxx     = i_sxx;
                    n_num_neg = 1'b0;
                    n_off_neg = 1'b0;
                    n_st      = SQ_MUL_A;
                    n_go      = 1'b1;
                end
            end
            SQ_MUL_A: begin
                o_alu_a = RW'(r_sxy);
                o_alu_b = RW'(r_n);
                if (cap) begin
                    n_ta = i_alu_res;
                    n_st = SQ_MUL_B;
                    n_go = 1'b1;
                end
            end
            SQ_MUL_B: begin
                o_alu_a = RW'(r_sx);
                o_alu_b = RW'(r_sy);
                if (cap) begin
                    n_tb = i_alu_res;
                    n_st = SQ_SUB_NUM;
                    n_go = 1'b1;
                end
            end
            SQ_SUB_NUM: begin
                o_alu_ctl.op = ALU_SUB;
                o_alu_a      = r_ta;
                o_alu_b      = r_tb;
                if (cap) begin
                    if (i_alu_sts.borrow) begin
                        n_num_neg = 1'b1;
                        n_st      = SQ_NEG_NUM;
                    end else begin
                        n_num = i_alu_res[PW-1:0];
                        n_st  = SQ_MUL_C;
                    end
                    n_go = 1'b1;
                end
            end
            SQ_NEG_NUM: begin
                o_alu_ctl.op = ALU_SUB;
                o_alu_a      = r_tb;
                o_alu_b      = r_ta;
                if (cap) begin
                    n_num = i_alu_res[PW-1:0];
                    n_st  = SQ_MUL_C;
                    n_go  = 1'b1;
                end
            end
            SQ_MUL_C: begin
                o_alu_a = RW'(r_sxx);
                o_alu_b = RW'(r_n);
                if (cap) begin
                    n_ta = i_alu_res;
                    n_st = SQ_MUL_D;
                    n_go = 1'b1;
                end
            end
            SQ_MUL_D: begin
                o_alu_a = RW'(r_sx);
                o_alu_b = RW'(r_sx);
                if (cap) begin
                    n_tb = i_alu_res;
                    n_st = SQ_SUB_DEN;
                    n_go = 1'b1;
                end
            end
            SQ_SUB_DEN: begin
                o_alu_ctl.op = ALU_SUB;
                o_alu_a      = r_ta;
                o_alu_b      = r_tb;
                if (cap) begin
                    if (i_alu_sts.borrow || (i_alu_res == '0)) begin
                        // all x equal or a single point: no fit
                        n_slope  = '0;
                        n_offset = '0;
                        n_deg    = 1'b1;
                        n_st     = SQ_EMIT;
                    end else begin
                        n_den = i_alu_res[PW-1:0];
                        n_deg = 1'b0;
                        n_st  = SQ_DIV_SLOPE;
                        n_go  = 1'b1;
                    end
                end
            end
            SQ_DIV_SLOPE: begin
                o_alu_ctl.op = ALU_DIV;
                o_alu_a      = RW'({r_num, {FRAC_BITS{1'b0}}});
                o_alu_b      = RW'(r_den);
                if (cap) begin
                    n_slope = f_sat(i_alu_res, r_num_neg);
                    n_st    = SQ_MUL_P;
                    n_go    = 1'b1;
                end
            end
            SQ_MUL_P: begin
                o_alu_a = RW'(r_den);
                o_alu_b = RW'(r_sy);
                if (cap) begin
                    n_ta = i_alu_res;
                    n_st = SQ_MUL_Q;
                    n_go = 1'b1;
                end
            end
            SQ_MUL_Q: begin
                o_alu_a = RW'(r_num);
                o_alu_b = RW'(r_sx);
                if (cap) begin
                    n_tb = i_alu_res;
                    n_st = SQ_OFF_SUM;
                    n_go = 1'b1;
                end
            end
            SQ_OFF_SUM: begin
                // Sy*den - num*Sx with the sign of num folded in
                o_alu_ctl.op = r_num_neg ? ALU_ADD : ALU_SUB;
                o_alu_a      = r_ta;
                o_alu_b      = r_tb;
                if (cap) begin
                    if (!r_num_neg && i_alu_sts.borrow) begin
                        n_off_neg = 1'b1;
                        n_st      = SQ_OFF_NEG;
                    end else begin
                        n_ta = i_alu_res;
                        n_st = SQ_MUL_ND;
                    end
                    n_go = 1'b1;
                end
            end
            SQ_OFF_NEG: begin
                o_alu_ctl.op = ALU_SUB;
                o_alu_a      = r_tb;
                o_alu_b      = r_ta;
                if (cap) begin
                    n_ta = i_alu_res;
                    n_st = SQ_MUL_ND;
                    n_go = 1'b1;
                end
            end
            SQ_MUL_ND: begin
                o_alu_a = RW'(r_den);
                o_alu_b = RW'(r_n);
                if (cap) begin
                    n_tb = i_alu_res;
                    n_st = SQ_DIV_OFF;
                    n_go = 1'b1;
                end
            end
            SQ_DIV_OFF: begin
                o_alu_ctl.op = ALU_DIV;
                o_alu_a      = {r_ta[RW-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
                o_alu_b      = r_tb;
                if (cap) begin
                    n_offset = f_sat(i_alu_res, r_off_neg);
                    n_st     = SQ_EMIT;
                end
            end
            SQ_EMIT: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out.slope_q     = r_slope;
                    n_out.offset_q    = r_offset;
                    n_out.degenerate  = r_deg;
                    n_out.points_used = POINTS_W'(r_n);
                    n_out_valid       = 1'b1;
                    n_st              = SQ_IDLE;
                end
            end
            default: begin
                n_st = SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= SQ_IDLE;
            r_go        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_st        <= n_st;
            r_go        <= n_go;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n       <= n_n;
        r_sx      <= n_sx;
        r_sy      <= n_sy;
        r_sxy     <= n_sxy;
        r_sxx     <= n_sxx;
        r_ta      <= n_ta;
        r_tb      <= n_tb;
        r_num     <= n_num;
        r_den     <= n_den;
        r_num_neg <= n_num_neg;
        r_off_neg <= n_off_neg;
        r_slope   <= n_slope;
        r_offset  <= n_offset;
        r_deg     <= n_deg;
        r_out     <= n_out;
    end

    assign o_busy      = (r_st != SQ_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTH
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_st == SQ_IDLE))
        else $error("set handed over while a fit is running");

    a_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_alu_sts.done |-> (r_st != SQ_IDLE && r_st != SQ_EMIT && !r_go))
        else $error("arithmetic unit finished with no operation pending");

    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.degenerate) |-> (r_out.slope_q == '0 && r_out.offset_q == '0))
        else $error("degenerate fit with non-zero results");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == SQ_EMIT && (!r_out_valid || i_out_ready)) |=> (r_out_valid && r_st == SQ_IDLE))
        else $error("finished fit not moved to the output register");
`endif

endmodule

[rtl/least_squares_line_fit_top.sv]
// A point without the last mark is added to the sums; ready stays high between sets.
// A closing point starts the fit: 7 multiplies, 3 or 4 add/subtract steps and 2 divides
// on one shared shift-add/subtract unit, then the result is loaded into the output register.
// A degenerate set ends after the denominator. Input ready is low meanwhile.
// Synchronous active-low reset clears the count, the sums, the sequencer and the output valid.
module least_squares_line_fit_top #(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  lslf_pkg::t_point i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output lslf_pkg::t_fit   o_out_data
);
    import lslf_pkg::*;

    localparam int CW = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam int SW = NW + CW;
    localparam int XW = NW + 2 * CW;
    localparam int PW = 2 * NW + 2 * CW;
    localparam int RW = SW + PW + 1 + FRAC_BITS;

    logic          accept;
    logic          fire;
    logic          seq_busy;
    logic [NW-1:0] acc_n;
    logic [SW-1:0] acc_sx, acc_sy;
    logic [XW-1:0] acc_sxy, acc_sxx;
    t_alu_ctl      alu_ctl;
    t_alu_sts      alu_sts;
    logic [RW-1:0] alu_a, alu_b, alu_res;

    assign o_in_ready = !seq_busy;
    assign accept     = i_in_valid && o_in_ready;

    lslf_accum #(
        .MAX_POINTS (MAX_POINTS),
        .CW         (CW),
        .NW         (NW),
        .SW         (SW),
        .XW         (XW)
    ) u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_point  (i_in_data),
        .o_fire   (fire),
        .o_n      (acc_n),
        .o_sx     (acc_sx),
        .o_sy     (acc_sy),
        .o_sxy    (acc_sxy),
        .o_sxx    (acc_sxx)
    );

    lslf_alu #(
        .RW (RW),
        .MW (SW)
    ) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (alu_ctl),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_sts   (alu_sts),
        .o_res   (alu_res)
    );

    lslf_seq #(
        .NW        (NW),
        .SW        (SW),
        .XW        (XW),
        .PW        (PW),
        .RW        (RW),
        .FRAC_BITS (FRAC_BITS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (fire),
        .i_n         (acc_n),
        .i_sx        (acc_sx),
        .i_sy        (acc_sy),
        .i_sxy       (acc_sxy),
        .i_sxx       (acc_sxx),
        .o_busy      (seq_busy),
        .o_alu_ctl   (alu_ctl),
        .o_alu_a     (alu_a),
        .o_alu_b     (alu_b),
        .i_alu_sts   (alu_sts),
        .i_alu_res   (alu_res),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
